// ===== sv/idv_pkg.sv =====
// ----------------------------------------------------------------------------
// idv_pkg: shared types, constants and functions of the ID number verifier
// Holds the character classes, field positions, verdict codes, register
// indexes and the small arithmetic helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package idv_pkg;

	localparam int REGION_ENTRIES = 16;
	localparam int ITEM_QUEUE_DEPTH = 4;
	localparam int RESULT_QUEUE_DEPTH = 2;

	localparam int YEAR_W = 14;
	localparam int POS_W = 5;
	localparam int CODE_W = 20;
	localparam int INDEX_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 1'b1;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd1900;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd2011;
	localparam logic [YEAR_W-1:0] LEAP_EXCEPTION_YEAR = 14'd1900;

	localparam logic OP_TABLE_WRITE = 1'b0;
	localparam logic OP_CHAR = 1'b1;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_X = 8'h58;

	localparam logic [POS_W-1:0] REGION_LAST = 5'd5;
	localparam logic [POS_W-1:0] YEAR_END = 5'd10;
	localparam logic [POS_W-1:0] MONTH_END = 5'd12;
	localparam logic [POS_W-1:0] DAY_END = 5'd14;
	localparam logic [POS_W-1:0] ID_DIGITS = 5'd17;

	localparam logic [3:0] CHECK_X_VALUE = 4'd10;

	localparam logic [1:0] VERDICT_INVALID = 2'd0;
	localparam logic [1:0] VERDICT_MALE = 2'd1;
	localparam logic [1:0] VERDICT_FEMALE = 2'd2;

	typedef struct packed {
		logic op;
		logic first;
		logic is_digit;
		logic is_x;
		logic [3:0] digit;
		logic [INDEX_W-1:0] entry_index;
		logic [CODE_W-1:0] entry_code;
		logic entry_valid;
	} item_t;

	typedef struct packed {
		logic [YEAR_W-1:0] min_year;
		logic [YEAR_W-1:0] max_year;
	} year_bounds_t;

	// Weight 2^(17-pos) reduced mod 11 for character positions 0 to 16.
	function automatic logic [3:0] weight_mod11(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		unique case (pos)
			5'd0: w = 4'd7;
			5'd1: w = 4'd9;
			5'd2: w = 4'd10;
			5'd3: w = 4'd5;
			5'd4: w = 4'd8;
			5'd5: w = 4'd4;
			5'd6: w = 4'd2;
			5'd7: w = 4'd1;
			5'd8: w = 4'd6;
			5'd9: w = 4'd3;
			5'd10: w = 4'd7;
			5'd11: w = 4'd9;
			5'd12: w = 4'd10;
			5'd13: w = 4'd5;
			5'd14: w = 4'd8;
			5'd15: w = 4'd4;
			5'd16: w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	// Reduces a value below 128 mod 11 by conditional subtraction.
	function automatic logic [3:0] mod11_small(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (r >= 7'd88) r = r - 7'd88;
		if (r >= 7'd44) r = r - 7'd44;
		if (r >= 7'd22) r = r - 7'd22;
		if (r >= 7'd11) r = r - 7'd11;
		return r[3:0];
	endfunction

	function automatic logic [4:0] days_in_month(input logic [YEAR_W-1:0] year,
			input logic [6:0] month);
		logic [4:0] days;
		priority if (month == 7'd2) begin
			days = (year[1:0] == 2'b00 && year != LEAP_EXCEPTION_YEAR) ? 5'd29 : 5'd28;
		end else if (month == 7'd4 || month == 7'd6 || month == 7'd9 || month == 7'd11) begin
			days = 5'd30;
		end else begin
			days = 5'd31;
		end
		return days;
	endfunction

endpackage

// ===== sv/idv_fifo.sv =====
// ----------------------------------------------------------------------------
// idv_fifo: small synchronous queue
// Register-based queue with power-of-two depth (at least two), used between
// the front and back parts and for the waiting results.
// ----------------------------------------------------------------------------
module idv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0] wr_ptr_q;
	logic [AW:0] rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

endmodule

// ===== sv/idv_front.sv =====
// ----------------------------------------------------------------------------
// idv_front: request intake and character classification
// Registers each accepted request, classifies its character as digit, 'X'
// or other, and hands it to the item queue.
// ----------------------------------------------------------------------------
module idv_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         op,
	input  logic [7:0]                   ch,
	input  logic                         first,
	input  logic [idv_pkg::INDEX_W-1:0]  entry_index,
	input  logic [idv_pkg::CODE_W-1:0]   entry_code,
	input  logic                         entry_valid,
	input  logic                         q_full,
	output logic                         q_push,
	output idv_pkg::item_t               q_item
);

	idv_pkg::item_t item_s1;
	logic valid_s1;
	logic accept;
	logic is_digit;

	assign full = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	assign is_digit = (ch >= idv_pkg::CHAR_ZERO) && (ch <= idv_pkg::CHAR_NINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op <= op;
			item_s1.first <= first;
			item_s1.is_digit <= is_digit;
			item_s1.is_x <= (ch == idv_pkg::CHAR_X);
			item_s1.digit <= is_digit ? 4'(ch - idv_pkg::CHAR_ZERO) : 4'd0;
			item_s1.entry_index <= entry_index;
			item_s1.entry_code <= entry_code;
			item_s1.entry_valid <= entry_valid;
		end
	end

endmodule

// ===== sv/idv_back.sv =====
// ----------------------------------------------------------------------------
// idv_back: region table, field accumulation and verdict
// Takes one classified request per cycle: table writes update the region
// table, characters build the ID fields and the weighted check sum, and the
// eighteenth character produces the verdict when the result queue has room.
// ----------------------------------------------------------------------------
module idv_back #(
	parameter int REGION_ENTRIES = idv_pkg::REGION_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  idv_pkg::item_t              item,
	input  logic                        item_empty,
	output logic                        item_pop,
	input  idv_pkg::year_bounds_t       bounds,
	input  logic                        res_full,
	output logic                        res_push,
	output logic [1:0]                  res_verdict
);

	localparam int SLOT_W = 9;

	logic [idv_pkg::CODE_W-1:0] table_q [REGION_ENTRIES];
	logic [REGION_ENTRIES-1:0] enabled_q;

	logic [idv_pkg::POS_W-1:0] pos_q;
	logic [idv_pkg::CODE_W-1:0] region_q;
	logic [idv_pkg::YEAR_W-1:0] year_q;
	logic [6:0] month_q;
	logic [6:0] day_q;
	logic [9:0] seq_q;
	logic [3:0] rem_q;
	logic bad_q;

	logic is_char;
	logic start;
	logic final_char;
	logic take;
	logic [idv_pkg::POS_W-1:0] pos;
	logic [idv_pkg::CODE_W-1:0] region_b;
	logic [idv_pkg::YEAR_W-1:0] year_b;
	logic [6:0] month_b;
	logic [6:0] day_b;
	logic [9:0] seq_b;
	logic [3:0] rem_b;
	logic bad_b;
	logic [3:0] d;

	logic [idv_pkg::CODE_W-1:0] region_n;
	logic [idv_pkg::YEAR_W-1:0] year_n;
	logic [6:0] month_n;
	logic [6:0] day_n;
	logic [9:0] seq_n;
	logic [3:0] rem_n;
	logic region_hit;
	logic bad_n;

	logic [3:0] check_value;
	logic [4:0] check_sum;
	logic year_ok;
	logic month_ok;
	logic day_ok;
	logic final_bad;

	assign is_char = (item.op == idv_pkg::OP_CHAR);
	assign start = item.first || (pos_q == '0);
	assign pos = start ? '0 : pos_q;
	assign region_b = start ? '0 : region_q;
	assign year_b = start ? '0 : year_q;
	assign month_b = start ? '0 : month_q;
	assign day_b = start ? '0 : day_q;
	assign seq_b = start ? '0 : seq_q;
	assign rem_b = start ? '0 : rem_q;
	assign bad_b = start ? 1'b0 : bad_q;
	assign d = item.digit;

	assign final_char = is_char && (pos == idv_pkg::ID_DIGITS);
	assign take = !item_empty && !(final_char && res_full);
	assign item_pop = take;

	assign region_n = (region_b << 3) + (region_b << 1) + idv_pkg::CODE_W'(d);
	assign year_n = (year_b << 3) + (year_b << 1) + idv_pkg::YEAR_W'(d);
	assign month_n = (month_b << 3) + (month_b << 1) + 7'(d);
	assign day_n = (day_b << 3) + (day_b << 1) + 7'(d);
	assign seq_n = (seq_b << 3) + (seq_b << 1) + 10'(d);
	assign rem_n = idv_pkg::mod11_small(7'(rem_b) + 7'(d) * 7'(idv_pkg::weight_mod11(pos)));

	always_comb begin
		region_hit = 1'b0;
		for (int i = 0; i < REGION_ENTRIES; i++) begin
			if (enabled_q[i] && table_q[i] == region_n) begin
				region_hit = 1'b1;
			end
		end
	end

	assign bad_n = bad_b || !item.is_digit || (pos == idv_pkg::REGION_LAST && !region_hit);

	assign check_value = item.is_digit ? item.digit : (item.is_x ? idv_pkg::CHECK_X_VALUE : 4'd0);
	assign check_sum = 5'(check_value) + 5'(rem_b);
	assign year_ok = (year_b >= bounds.min_year) && (year_b <= bounds.max_year);
	assign month_ok = (month_b >= 7'd1) && (month_b <= 7'd12);
	assign day_ok = (day_b >= 7'd1) && (day_b <= 7'(idv_pkg::days_in_month(year_b, month_b)));
	assign final_bad = bad_b || !(item.is_digit || item.is_x) || !year_ok || !month_ok
		|| !day_ok || (seq_b == '0) || !(check_sum == 5'd1 || check_sum == 5'd12);

	assign res_push = take && final_char;
	assign res_verdict = final_bad ? idv_pkg::VERDICT_INVALID
		: (seq_b[0] ? idv_pkg::VERDICT_MALE : idv_pkg::VERDICT_FEMALE);

	always_ff @(posedge clk) begin
		for (int i = 0; i < REGION_ENTRIES; i++) begin
			if (take && !is_char && {5'd0, item.entry_index} == SLOT_W'(i)) begin
				table_q[i] <= item.entry_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
		end else begin
			for (int i = 0; i < REGION_ENTRIES; i++) begin
				if (take && !is_char && {5'd0, item.entry_index} == SLOT_W'(i)) begin
					enabled_q[i] <= item.entry_valid;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			region_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			seq_q <= '0;
			rem_q <= '0;
			bad_q <= 1'b0;
		end else if (take && is_char) begin
			if (final_char) begin
				pos_q <= '0;
				region_q <= '0;
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				seq_q <= '0;
				rem_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pos_q <= pos + 1'b1;
				rem_q <= rem_n;
				bad_q <= bad_n;
				region_q <= (pos <= idv_pkg::REGION_LAST) ? region_n : region_b;
				year_q <= (pos > idv_pkg::REGION_LAST && pos < idv_pkg::YEAR_END)
					? year_n : year_b;
				month_q <= (pos >= idv_pkg::YEAR_END && pos < idv_pkg::MONTH_END)
					? month_n : month_b;
				day_q <= (pos >= idv_pkg::MONTH_END && pos < idv_pkg::DAY_END)
					? day_n : day_b;
				seq_q <= (pos >= idv_pkg::DAY_END) ? seq_n : seq_b;
			end
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= idv_pkg::ID_DIGITS)
		else $error("Character position ran past the check character.");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("Verdict produced while the result queue was full.");

	a_restart_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_char) |=> (pos_q == '0 && !bad_q))
		else $error("ID state not cleared after the check character.");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_char && !final_char) |=> (pos_q == $past(pos) + 1'b1))
		else $error("Character position did not advance on a character.");

endmodule

// ===== sv/id_number_verifier_core.sv =====
// ----------------------------------------------------------------------------
// id_number_verifier_core: 18-character ID number verifier
// Loads a table of region codes and checks ID numbers one character per
// request, producing an invalid, male or female verdict per ID.
// ----------------------------------------------------------------------------
// Requests enter through push/full; each carries either a region table write
// (op 0) or one ASCII character of an ID (op 1, first marks a new ID).
// Verdicts leave through empty/pop, oldest first, one per completed ID.
// A request is registered and classified in the front part, waits in a
// four-entry queue, and is taken by the back part, which holds the region
// table and the running ID fields. One request is accepted per cycle while
// full is low. The verdict of an eighteenth character is written into the
// result queue, from which it reaches the result ports.
// If the receiver does not pop, verdicts fill the two-entry result queue;
// the back part then holds the next eighteenth character, the item queue
// fills, and full rises. Table writes and other characters keep flowing
// until such a character reaches the back part.
// Reset clears the queues, the table's enable bits and the ID state, and
// sets the year bounds to 1900 and 2011. The user must write year bounds
// through cfg_write while no request is in flight; the block does not check.
// ----------------------------------------------------------------------------
module id_number_verifier_core #(
	parameter int REGION_ENTRIES = idv_pkg::REGION_ENTRIES,
	parameter int ITEM_QUEUE_DEPTH = idv_pkg::ITEM_QUEUE_DEPTH,
	parameter int RESULT_QUEUE_DEPTH = idv_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic [7:0]                    ch,
	input  logic                          first,
	input  logic [idv_pkg::INDEX_W-1:0]   entry_index,
	input  logic [idv_pkg::CODE_W-1:0]    entry_code,
	input  logic                          entry_valid,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    verdict,
	input  logic                          cfg_write,
	input  logic [idv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [idv_pkg::YEAR_W-1:0]    cfg_data
);

	idv_pkg::year_bounds_t bounds_q;
	idv_pkg::item_t front_item;
	idv_pkg::item_t back_item;
	logic front_push;
	logic item_full;
	logic item_empty;
	logic item_pop;
	logic res_full;
	logic res_push;
	logic [1:0] res_verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q.min_year <= idv_pkg::MIN_YEAR_RESET;
			bounds_q.max_year <= idv_pkg::MAX_YEAR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				idv_pkg::REG_MIN_YEAR: bounds_q.min_year <= cfg_data;
				idv_pkg::REG_MAX_YEAR: bounds_q.max_year <= cfg_data;
			endcase
		end
	end

	idv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.ch          (ch),
		.first       (first),
		.entry_index (entry_index),
		.entry_code  (entry_code),
		.entry_valid (entry_valid),
		.q_full      (item_full),
		.q_push      (front_push),
		.q_item      (front_item)
	);

	idv_fifo #(
		.WIDTH ($bits(idv_pkg::item_t)),
		.DEPTH (ITEM_QUEUE_DEPTH)
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_item),
		.full    (item_full),
		.rd_en   (item_pop),
		.rd_data (back_item),
		.empty   (item_empty)
	);

	idv_back #(
		.REGION_ENTRIES (REGION_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (back_item),
		.item_empty  (item_empty),
		.item_pop    (item_pop),
		.bounds      (bounds_q),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_verdict (res_verdict)
	);

	idv_fifo #(
		.WIDTH (2),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_verdict),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (verdict),
		.empty   (empty)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ID number verifier
// Loads region codes and feeds whole ID numbers, broken ones and loose
// characters one request at a time. Every accepted request updates a local
// prediction of the verdicts, which are compared in order with the verdicts
// popped from the block. Phases change the year bounds and the idle pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import idv_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam int MAX_REGION_CODE = 999999;
	localparam int MAX_YEAR_VALUE = 9999;
	localparam int ID_CHARS = 18;

	typedef struct packed {
		logic op;
		logic [7:0] ch;
		logic first;
		logic [INDEX_W-1:0] idx;
		logic [CODE_W-1:0] code;
		logic valid;
	} id_request_t;

	typedef enum int {
		ID_GOOD,
		ID_BAD_CHAR,
		ID_BAD_CHECK_CHAR,
		ID_WRONG_CHECK,
		ID_NO_REGION,
		ID_YEAR_OUT,
		ID_BAD_MONTH,
		ID_BAD_DAY,
		ID_ZERO_SEQ,
		ID_FEB_29
	} id_shape_t;

	localparam int BAD_SHAPES = int'(ID_FEB_29) - int'(ID_BAD_CHAR) + 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic op = 1'b0;
	logic [7:0] ch = 8'd0;
	logic first = 1'b0;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [CODE_W-1:0] entry_code = '0;
	logic entry_valid = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] verdict;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [YEAR_W-1:0] cfg_data = '0;

	// Predicted state of the block, advanced on every accepted request.
	logic [CODE_W-1:0] tbl_code [REGION_ENTRIES] = '{default: '0};
	logic tbl_on [REGION_ENTRIES] = '{default: 1'b0};
	logic [POS_W-1:0] cur_pos = '0;
	logic [CODE_W-1:0] acc_region = '0;
	logic [YEAR_W-1:0] acc_year = '0;
	logic [6:0] acc_month = '0;
	logic [6:0] acc_day = '0;
	logic [9:0] acc_seq = '0;
	logic [3:0] acc_rem = '0;
	logic id_bad = 1'b0;
	logic [YEAR_W-1:0] lo_year = MIN_YEAR_RESET;
	logic [YEAR_W-1:0] hi_year = MAX_YEAR_RESET;
	logic [1:0] expected_verdicts [$];

	// The stimulus side keeps its own view of the table and the character
	// position, since it runs ahead of the accepted requests.
	id_request_t pending [$];
	logic [CODE_W-1:0] plan_code [REGION_ENTRIES] = '{default: '0};
	logic plan_on [REGION_ENTRIES] = '{default: 1'b0};
	int plan_pos = 0;
	int bad_turn = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int quiet_cycles = 0;

	id_number_verifier_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.ch(ch),
		.first(first),
		.entry_index(entry_index),
		.entry_code(entry_code),
		.entry_valid(entry_valid),
		.empty(empty),
		.pop(pop),
		.verdict(verdict),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int pos_weight(input int p);
		int w;
		w = 1;
		for (int k = p; k < ID_DIGITS; k++) w = (w * 2) % 11;
		return w;
	endfunction

	function automatic int month_length(input int year, input int month);
		if (month == 2) return (year % 4 == 0 && year != LEAP_EXCEPTION_YEAR) ? 29 : 28;
		if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
		return 31;
	endfunction

	function automatic logic is_digit_char(input logic [7:0] c);
		return c >= CHAR_ZERO && c <= CHAR_NINE;
	endfunction

	task automatic clear_id_fields();
		cur_pos = '0;
		acc_region = '0;
		acc_year = '0;
		acc_month = '0;
		acc_day = '0;
		acc_seq = '0;
		acc_rem = '0;
		id_bad = 1'b0;
	endtask

	task automatic predict_verdict(input id_request_t r);
		int d;
		int check_val;
		logic hit;
		if (r.op == OP_TABLE_WRITE) begin
			tbl_code[r.idx] = r.code;
			tbl_on[r.idx] = r.valid;
		end else begin
			if (r.first || cur_pos == 0) clear_id_fields();
			d = is_digit_char(r.ch) ? int'(r.ch - CHAR_ZERO) : 0;
			if (cur_pos < ID_DIGITS) begin
				if (!is_digit_char(r.ch)) id_bad = 1'b1;
				acc_rem = 4'((int'(acc_rem) + d * pos_weight(int'(cur_pos))) % 11);
				if (cur_pos <= REGION_LAST) begin
					acc_region = CODE_W'(int'(acc_region) * 10 + d);
					if (cur_pos == REGION_LAST) begin
						hit = 1'b0;
						for (int i = 0; i < REGION_ENTRIES; i++) begin
							if (tbl_on[i] && tbl_code[i] == acc_region) hit = 1'b1;
						end
						if (!hit) id_bad = 1'b1;
					end
				end else if (cur_pos < YEAR_END) begin
					acc_year = YEAR_W'(int'(acc_year) * 10 + d);
				end else if (cur_pos < MONTH_END) begin
					acc_month = 7'(int'(acc_month) * 10 + d);
				end else if (cur_pos < DAY_END) begin
					acc_day = 7'(int'(acc_day) * 10 + d);
				end else begin
					acc_seq = 10'(int'(acc_seq) * 10 + d);
				end
				cur_pos = cur_pos + 1'b1;
			end else begin
				if (is_digit_char(r.ch)) begin
					check_val = d;
				end else if (r.ch == CHAR_X) begin
					check_val = int'(CHECK_X_VALUE);
				end else begin
					check_val = 0;
					id_bad = 1'b1;
				end
				if (acc_year < lo_year || acc_year > hi_year) id_bad = 1'b1;
				if (acc_month < 1 || acc_month > 12) begin
					id_bad = 1'b1;
				end else if (acc_day < 1 ||
						acc_day > month_length(int'(acc_year), int'(acc_month))) begin
					id_bad = 1'b1;
				end
				if (acc_seq == 0) id_bad = 1'b1;
				if ((check_val + int'(acc_rem)) % 11 != 1) id_bad = 1'b1;
				if (id_bad) expected_verdicts.push_back(VERDICT_INVALID);
				else if (acc_seq[0]) expected_verdicts.push_back(VERDICT_MALE);
				else expected_verdicts.push_back(VERDICT_FEMALE);
				clear_id_fields();
			end
		end
	endtask

	task automatic queue_request(input id_request_t r);
		pending.push_back(r);
		if (r.op == OP_TABLE_WRITE) begin
			plan_code[r.idx] = r.code;
			plan_on[r.idx] = r.valid;
		end else begin
			if (r.first || plan_pos == 0) plan_pos = 0;
			plan_pos = (plan_pos == ID_DIGITS) ? 0 : plan_pos + 1;
		end
	endtask

	function automatic id_request_t char_request(input logic [7:0] c, input logic f);
		id_request_t r;
		r.op = OP_CHAR;
		r.ch = c;
		r.first = f;
		r.idx = INDEX_W'($urandom);
		r.code = CODE_W'($urandom);
		r.valid = 1'($urandom);
		return r;
	endfunction

	function automatic id_request_t table_request(input int slot,
			input logic [CODE_W-1:0] code, input logic on);
		id_request_t r;
		r.op = OP_TABLE_WRITE;
		r.ch = 8'($urandom);
		r.first = 1'($urandom);
		r.idx = INDEX_W'(slot);
		r.code = code;
		r.valid = on;
		return r;
	endfunction

	// Builds one complete ID of the given shape from the planned table and
	// year bounds; only the named field is broken, the rest is legal if lo <= hi.
	task automatic queue_id(input id_shape_t shape, input bit want_x);
		int digits [ID_DIGITS];
		logic [7:0] text [ID_CHARS];
		int usable [$];
		int slot, year, month, day, dim, seq, rem, cv, write_at, lo, hi;
		logic [CODE_W-1:0] rcode;
		logic [7:0] c;
		logic clash;
		longint unsigned num;
		lo = int'(lo_year);
		hi = int'(hi_year);
		for (int i = 0; i < REGION_ENTRIES; i++) begin
			if (plan_on[i] && plan_code[i] <= MAX_REGION_CODE) usable.push_back(i);
		end
		if (usable.size() == 0 || $urandom_range(7) == 0) begin
			slot = $urandom_range(REGION_ENTRIES - 1);
			rcode = CODE_W'($urandom_range(MAX_REGION_CODE));
			queue_request(table_request(slot, rcode, 1'b1));
		end else begin
			slot = usable[$urandom_range(usable.size() - 1)];
			rcode = plan_code[slot];
		end
		if (shape == ID_NO_REGION) begin
			do begin
				rcode = CODE_W'($urandom_range(MAX_REGION_CODE));
				clash = 1'b0;
				for (int i = 0; i < REGION_ENTRIES; i++) begin
					if (plan_on[i] && plan_code[i] == rcode) clash = 1'b1;
				end
			end while (clash);
		end
		if (lo <= hi) begin
			case ($urandom_range(3))
				0: year = lo;
				1: year = hi;
				default: year = $urandom_range(hi, lo);
			endcase
		end else begin
			year = $urandom_range(MAX_YEAR_VALUE);
		end
		if (shape == ID_YEAR_OUT) begin
			if (lo > 0 && (hi >= MAX_YEAR_VALUE || $urandom_range(1) == 1))
				year = $urandom_range(lo - 1);
			else if (hi < MAX_YEAR_VALUE)
				year = $urandom_range(MAX_YEAR_VALUE, hi + 1);
		end
		month = $urandom_range(12, 1);
		dim = month_length(year, month);
		day = ($urandom_range(3) == 0) ? dim : $urandom_range(dim, 1);
		case (shape)
			ID_BAD_MONTH: month = ($urandom_range(1) == 1) ? 0 : $urandom_range(99, 13);
			ID_BAD_DAY: day = ($urandom_range(1) == 1) ? 0 : $urandom_range(99, dim + 1);
			ID_FEB_29: begin
				month = 2;
				day = 29;
			end
			default: ;
		endcase
		seq = (shape == ID_ZERO_SEQ) ? 0 : $urandom_range(999, 1);
		do begin
			num = longint'(rcode) * 64'd100000000000 + longint'(year) * 64'd10000000
				+ longint'(month) * 64'd100000 + longint'(day) * 64'd1000 + longint'(seq);
			rem = 0;
			for (int p = ID_DIGITS - 1; p >= 0; p--) begin
				digits[p] = int'(num % 10);
				num = num / 10;
			end
			for (int p = 0; p < ID_DIGITS; p++) rem = (rem + digits[p] * pos_weight(p)) % 11;
			cv = (12 - rem) % 11;
			if (want_x && cv != CHECK_X_VALUE) seq = $urandom_range(999, 1);
		end while (want_x && cv != CHECK_X_VALUE);
		if (shape == ID_WRONG_CHECK) cv = (cv + $urandom_range(10, 1)) % 11;
		for (int p = 0; p < ID_DIGITS; p++) text[p] = 8'(int'(CHAR_ZERO) + digits[p]);
		text[ID_CHARS - 1] = (cv == CHECK_X_VALUE) ? CHAR_X : 8'(int'(CHAR_ZERO) + cv);
		if (shape == ID_BAD_CHAR) begin
			do c = 8'($urandom); while (is_digit_char(c));
			text[$urandom_range(ID_DIGITS - 1)] = c;
		end
		if (shape == ID_BAD_CHECK_CHAR) begin
			do c = 8'($urandom); while (is_digit_char(c) || c == CHAR_X);
			text[ID_CHARS - 1] = c;
		end
		// A table write after the region code has been decided must not
		// change the verdict of this ID.
		write_at = ($urandom_range(4) == 0) ? $urandom_range(ID_CHARS - 1, 6) : -1;
		for (int p = 0; p < ID_CHARS; p++) begin
			if (p == write_at) begin
				if ($urandom_range(1) == 1)
					queue_request(table_request(slot, rcode, 1'($urandom)));
				else
					queue_request(table_request($urandom_range(REGION_ENTRIES - 1),
						CODE_W'($urandom), 1'($urandom)));
			end
			if (p == 0)
				queue_request(char_request(text[p], plan_pos != 0 || $urandom_range(1) == 1));
			else
				queue_request(char_request(text[p], 1'b0));
		end
	endtask

	task automatic queue_noise();
		int n;
		logic [7:0] c;
		n = $urandom_range(ID_DIGITS, 1);
		for (int p = 0; p < n; p++) begin
			if ($urandom_range(5) == 0)
				queue_request(table_request($urandom_range(REGION_ENTRIES - 1),
					CODE_W'($urandom), 1'($urandom)));
			c = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(int'(CHAR_ZERO) + $urandom_range(9));
			queue_request(char_request(c, $urandom_range(7) == 0));
		end
	endtask

	task automatic set_phase(input int lo, input int hi, input int send_pct, input int recv_pct);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_MIN_YEAR;
		cfg_data <= YEAR_W'(lo);
		@(negedge clk);
		cfg_index <= REG_MAX_YEAR;
		cfg_data <= YEAR_W'(hi);
		@(negedge clk);
		cfg_write <= 1'b0;
		lo_year = YEAR_W'(lo);
		hi_year = YEAR_W'(hi);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic drain_all();
		while (pending.size() != 0 || expected_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int lo, input int hi, input int send_pct,
			input int recv_pct, input int ids, input bit long_hold);
		int pick;
		set_phase(lo, hi, send_pct, recv_pct);
		if (long_hold) hold_req = ~hold_req;
		for (int n = 0; n < ids; n++) begin
			if ($urandom_range(3) == 0)
				queue_request(table_request($urandom_range(REGION_ENTRIES - 1),
					CODE_W'($urandom_range(MAX_REGION_CODE)), 1'($urandom)));
			pick = $urandom_range(99);
			if (pick < 50) begin
				queue_id(ID_GOOD, 1'b0);
			end else if (pick < 85) begin
				queue_id(id_shape_t'(int'(ID_BAD_CHAR) + bad_turn % BAD_SHAPES), 1'b0);
				bad_turn++;
			end else begin
				queue_noise();
			end
		end
		drain_all();
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			{op, ch, first, entry_index, entry_code, entry_valid} <= pending[0];
		end else begin
			push <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : verdict_check
		id_request_t seen;
		logic [1:0] want;
		if (arst_n) begin
			if (push && !full) begin
				seen = {op, ch, first, entry_index, entry_code, entry_valid};
				predict_verdict(seen);
				void'(pending.pop_front());
			end
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: verdict %0d arrived with none expected", $time, verdict);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict !== want) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("%0t: verdict mismatch, expected %0d, actual %0d",
								$time, want, verdict);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_phase(int'(MIN_YEAR_RESET), int'(MAX_YEAR_RESET), 0, 0);
		queue_request(table_request(0, '0, 1'b1));
		queue_request(table_request(REGION_ENTRIES - 1, CODE_W'(MAX_REGION_CODE), 1'b1));
		queue_request(table_request(7, '1, 1'b1));
		queue_request(table_request(3, CODE_W'(110105), 1'b1));
		queue_request(table_request(3, CODE_W'(110105), 1'b0));
		// A cut-off ID made of the character extremes; the next ID restarts it.
		queue_request(char_request(8'h00, 1'b1));
		queue_request(char_request(8'hFF, 1'b0));
		queue_id(ID_GOOD, 1'b1);
		queue_id(ID_FEB_29, 1'b0);
		queue_id(ID_GOOD, 1'b0);
		drain_all();

		random_phase(int'(MIN_YEAR_RESET), int'(MAX_YEAR_RESET), 0, 0, 5, 1'b0);
		random_phase(0, MAX_YEAR_VALUE, 66, 0, 5, 1'b0);
		random_phase(MAX_YEAR_VALUE, MAX_YEAR_VALUE, 0, 66, 5, 1'b0);
		random_phase(1900, 1900, 15, 15, 5, 1'b0);
		random_phase(2000, 2000, 0, 0, 7, 1'b1);
		random_phase(0, 0, 66, 0, 5, 1'b0);
		random_phase(2011, 1900, 0, 66, 5, 1'b0);
		random_phase(1970, 2030, 15, 15, 5, 1'b0);

		if (errors == 0 && expected_verdicts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/idv_pkg.sv
sv/idv_fifo.sv
sv/idv_front.sv
sv/idv_back.sv
sv/id_number_verifier_core.sv
sim/tb_top.sv
